FILE: design/tzad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants for the telemetry z-score anomaly detector.
// Used by the channel interfaces and by the top level; depends on nothing.
package tzad_pkg;

   // Payload widths of the request and response channels.
   localparam int METRIC_W   = 16;
   localparam int OP_W       = 2;
   localparam int FLAGS_W    = 5;

   // Request operation codes. The reserved code is accepted and ignored.
   localparam logic [OP_W-1:0] OP_LEARN    = 2'd0;
   localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
   localparam logic [OP_W-1:0] OP_DETECT   = 2'd2;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   // Configuration port layout and register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 1'd1;
   localparam int WINDOW_LEN_W = 7;

   // Register reset values.
   localparam logic [15:0]             Z_LIMIT_RESET    = 16'd768;
   localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 7'd8;

   // Default sizes.
   localparam int HISTORY_DEPTH_DEF    = 64;
   localparam int LEARN_COUNT_BITS_DEF = 20;

endpackage : tzad_pkg
`default_nettype wire

FILE: design/tzad_channels_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels for requests and responses of the anomaly detector.
// Depends on tzad_pkg for the payload widths.
interface tzad_req_if;
   import tzad_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [METRIC_W-1:0] cache_rate;
   logic [METRIC_W-1:0] branch_rate;
   logic [METRIC_W-1:0] ipc_value;

   modport source (output valid, op, cache_rate, branch_rate, ipc_value, input ready);
   modport sink   (input valid, op, cache_rate, branch_rate, ipc_value, output ready);
endinterface : tzad_req_if

interface tzad_rsp_if;
   import tzad_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [METRIC_W-1:0] z_cache;
   logic signed [METRIC_W-1:0] z_branch;
   logic signed [METRIC_W-1:0] z_ipc;
   logic [FLAGS_W-1:0]         flags;
   logic [METRIC_W-1:0]        anomaly_streak;
   logic [METRIC_W-1:0]        score;

   modport source (output valid, z_cache, z_branch, z_ipc, flags, anomaly_streak, score,
                   input ready);
   modport sink   (input valid, z_cache, z_branch, z_ipc, flags, anomaly_streak, score,
                   output ready);
endinterface : tzad_rsp_if
`default_nettype wire

FILE: design/telemetry_zscore_anomaly_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the telemetry z-score anomaly detector.
// Depends on tzad_pkg and on the channel interfaces in tzad_channels_if.sv.

// The block takes one request at a time and accepts the next one when it is back
// in idle; a finished response waits in an output register, so requests keep
// flowing while the response is not yet taken, until a detect needs the register
// for its own response. A finalize runs, for each metric, a mean division and,
// with two or more samples, a mean-square division, the squared mean, the
// variance and a square root. A detect runs three z-score divisions and the
// score division on the shared bit-serial divider, plus one read per history
// entry of the recent cache ring (as many as the effective window length),
// which lives in a memory with one write port and one registered read port,
// read once a cycle. A metric with zero spread skips its division. A detect
// before the first finalize responds with zeros. The ring needs no clearing
// pass: per-entry valid bits make unwritten entries read as zero right after reset.
module telemetry_zscore_anomaly_detector #(
   parameter int HISTORY_DEPTH    = tzad_pkg::HISTORY_DEPTH_DEF,
   parameter int LEARN_COUNT_BITS = tzad_pkg::LEARN_COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tzad_req_if.sink                            req_chan,
   tzad_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [tzad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tzad_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tzad_pkg::*;

   localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW     = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = METRIC_W + LEARN_COUNT_BITS;
   localparam int SQS_W  = 2 * METRIC_W + LEARN_COUNT_BITS;
   localparam int DVW    = SQS_W;
   localparam int DDW    = (LEARN_COUNT_BITS > METRIC_W + 1) ? LEARN_COUNT_BITS : METRIC_W + 1;
   localparam int STEP_W = $clog2(DVW);
   localparam int SQ_STEPS = METRIC_W;
   localparam logic [1:0] METRIC_LAST = 2'd2;

   // Direction codes of the oscillation walk.
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_LEARN_SQ, S_LEARN_ACC, S_FIN_MEAN_DIV, S_FIN_EX2_DIV, S_FIN_MSQ,
      S_FIN_VAR, S_FIN_SQRT, S_DET_LOAD, S_DET_DIV, S_DET_FLAGS, S_OSC,
      S_SCORE_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [15:0]             z_limit_ff;
   logic [WINDOW_LEN_W-1:0] window_len_ff;

   // Baseline state.
   logic [SUM_W-1:0]            sum_ff   [3];
   logic [SQS_W-1:0]            sqs_ff   [3];
   logic [LEARN_COUNT_BITS-1:0] learn_count_ff;
   logic [METRIC_W-1:0]         mean_ff  [3];
   logic [METRIC_W-1:0]         std_ff   [3];
   logic                        baseline_ready_ff;
   logic [AW-1:0]               ring_pos_ff;
   logic [15:0]                 run_ff;

   // Working registers for the request in progress.
   logic [METRIC_W-1:0]   x_ff  [3];
   logic [2*METRIC_W-1:0] sq_ff [3];
   logic [1:0]            midx_ff;
   logic [2*METRIC_W-1:0] ex2_ff;
   logic [2*METRIC_W-1:0] msq_ff;
   logic signed [15:0]    z_ff  [3];
   logic                  zneg_ff;
   logic [FLAGS_W-1:0]    flags_ff;
   logic [15:0]           res_count_ff;
   logic [15:0]           score_ff;

   // Shared bit-serial divider and square-root unit.
   logic [DVW-1:0]    div_num_ff;
   logic [DDW-1:0]    div_den_ff;
   logic [DDW-1:0]    div_rem_ff;
   logic [STEP_W-1:0] step_cnt_ff;
   logic [31:0]       sq_val_ff;
   logic [17:0]       sq_rem_ff;
   logic [15:0]       sq_root_ff;

   // Oscillation walk over the ring.
   logic [AW-1:0] osc_addr_ff;
   logic [CW-1:0] osc_left_ff;
   logic          osc_pend_ff;
   logic          osc_first_ff;
   logic [15:0]   osc_prev_ff;
   logic [1:0]    osc_dir_ff;
   logic [CW-1:0] osc_changes_ff;

   // Response register.
   logic                rsp_valid_ff;
   logic signed [15:0]  rsp_z_ff [3];
   logic [FLAGS_W-1:0]  rsp_flags_ff;
   logic [15:0]         rsp_count_ff;
   logic [15:0]         rsp_score_ff;

   // Ring memory with per-entry valid bits.
   logic [15:0]              ring_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] ring_vld_ff;
   logic [15:0]              ring_rd_ff;
   logic                     ring_rd_vld_ff;
   logic                     ring_we;
   logic [AW-1:0]            ring_wa;

   // Divider step: restoring, one quotient bit per cycle.
   logic [DDW:0]   div_rem_sh;
   logic           div_ge;
   logic [DDW:0]   div_rem_sub;
   logic [DVW-1:0] div_quo;
   always_comb begin
      div_rem_sh  = {div_rem_ff, div_num_ff[DVW-1]};
      div_ge      = div_rem_sh >= {1'b0, div_den_ff};
      div_rem_sub = div_ge ? (div_rem_sh - {1'b0, div_den_ff}) : div_rem_sh;
      div_quo     = {div_num_ff[DVW-2:0], div_ge};
   end

   // Square-root step: two radicand bits per cycle.
   logic [19:0] sq_rem_sh;
   logic [19:0] sq_trial;
   logic        sq_ge;
   logic [19:0] sq_rem_sub;
   logic [15:0] sq_root_nx;
   always_comb begin
      sq_rem_sh  = {sq_rem_ff, sq_val_ff[31:30]};
      sq_trial   = {2'b00, sq_root_ff, 2'b01};
      sq_ge      = sq_rem_sh >= sq_trial;
      sq_rem_sub = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
      sq_root_nx = {sq_root_ff[14:0], sq_ge};
   end

   // Effective window length and ring write position.
   logic [CW-1:0] cap;
   logic [AW-1:0] pos_sel;
   logic [AW-1:0] pos_next;
   always_comb begin
      if (window_len_ff == '0) begin
         cap = CW'(1);
      end else if (32'(window_len_ff) > 32'(HISTORY_DEPTH)) begin
         cap = CW'(HISTORY_DEPTH);
      end else begin
         cap = CW'(window_len_ff);
      end
      pos_sel  = (CW'(ring_pos_ff) < cap) ? ring_pos_ff : '0;
      pos_next = ((CW'(pos_sel) + CW'(1)) == cap) ? '0 : (pos_sel + AW'(1));
   end

   // Threshold checks and run update for the current sample.
   logic [2:0]  spike;
   logic        anom;
   logic [15:0] run_nx;
   logic        burst;
   always_comb begin
      spike[0] = $signed({{2{z_ff[0][15]}}, z_ff[0]}) > $signed({2'b00, z_limit_ff});
      spike[1] = $signed({{2{z_ff[1][15]}}, z_ff[1]}) > $signed({2'b00, z_limit_ff});
      spike[2] = $signed({{2{z_ff[2][15]}}, z_ff[2]}) < -$signed({2'b00, z_limit_ff});
      anom     = |spike;
      if (!anom) begin
         run_nx = '0;
      end else if (run_ff == 16'hFFFF) begin
         run_nx = run_ff;
      end else begin
         run_nx = run_ff + 16'd1;
      end
      burst = anom && (32'(run_nx) >= 32'(cap));
   end

   // Direction of the newer entry against the older one just read.
   logic [15:0] osc_entry;
   logic [1:0]  osc_dir;
   logic        osc_done;
   logic        osc_flag;
   always_comb begin
      osc_entry = ring_rd_vld_ff ? ring_rd_ff : '0;
      if (osc_prev_ff > osc_entry) begin
         osc_dir = DIR_UP;
      end else if (osc_prev_ff < osc_entry) begin
         osc_dir = DIR_DOWN;
      end else begin
         osc_dir = DIR_NONE;
      end
      osc_done = (osc_left_ff == '0) && !osc_pend_ff;
      osc_flag = (cap >= CW'(4)) && (osc_changes_ff >= (cap >> 1));
   end

   // Largest absolute z-score and score denominator.
   logic [15:0] zabs [3];
   logic [15:0] maxz;
   logic [16:0] score_den;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         zabs[k] = z_ff[k][15] ? (16'd0 - z_ff[k]) : z_ff[k];
      end
      maxz = zabs[0];
      if (zabs[1] > maxz) maxz = zabs[1];
      if (zabs[2] > maxz) maxz = zabs[2];
      score_den = {1'b0, z_limit_ff} + {1'b0, maxz};
   end

   // Magnitude of the deviation of the current metric from its mean.
   logic [METRIC_W:0]   dev;
   logic [METRIC_W-1:0] dev_mag;
   always_comb begin
      dev     = {1'b0, x_ff[midx_ff]} - {1'b0, mean_ff[midx_ff]};
      dev_mag = dev[METRIC_W] ? METRIC_W'(-dev) : dev[METRIC_W-1:0];
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign ring_we        = (state_ff == S_DET_FLAGS);
   assign ring_wa        = pos_sel;

   // Sequencer: state, baseline, divider, walk and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         z_limit_ff        <= Z_LIMIT_RESET;
         window_len_ff     <= WINDOW_LEN_RESET;
         learn_count_ff    <= '0;
         baseline_ready_ff <= 1'b0;
         ring_pos_ff       <= '0;
         run_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]  <= '0;
            sqs_ff[k]  <= '0;
            mean_ff[k] <= '0;
            std_ff[k]  <= '0;
         end
      end else begin
         // Configuration writes.
         if (csr_we) begin
            if (csr_index == CSR_Z_LIMIT) begin
               z_limit_ff <= csr_wdata[15:0];
            end else if (csr_index == CSR_WINDOW_LEN) begin
               window_len_ff <= csr_wdata[WINDOW_LEN_W-1:0];
            end
         end

         // A taken response empties the register unless a new one loads now.
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  x_ff[0] <= req_chan.cache_rate;
                  x_ff[1] <= req_chan.branch_rate;
                  x_ff[2] <= req_chan.ipc_value;
                  midx_ff <= '0;
                  unique case (req_chan.op)
                     OP_LEARN: begin
                        if (!(&learn_count_ff)) state_ff <= S_LEARN_SQ;
                     end
                     OP_FINALIZE: begin
                        if (learn_count_ff != '0) begin
                           div_num_ff  <= DVW'(sum_ff[0]);
                           div_den_ff  <= DDW'(learn_count_ff);
                           div_rem_ff  <= '0;
                           step_cnt_ff <= STEP_W'(DVW - 1);
                           state_ff    <= S_FIN_MEAN_DIV;
                        end
                     end
                     OP_DETECT: begin
                        if (baseline_ready_ff) begin
                           state_ff <= S_DET_LOAD;
                        end else begin
                           for (int k = 0; k < 3; k++) z_ff[k] <= '0;
                           flags_ff     <= '0;
                           res_count_ff <= '0;
                           score_ff     <= '0;
                           state_ff     <= S_OUT;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            S_LEARN_SQ: begin
               for (int k = 0; k < 3; k++) sq_ff[k] <= x_ff[k] * x_ff[k];
               state_ff <= S_LEARN_ACC;
            end

            S_LEARN_ACC: begin
               for (int k = 0; k < 3; k++) begin
                  sum_ff[k] <= sum_ff[k] + SUM_W'(x_ff[k]);
                  sqs_ff[k] <= sqs_ff[k] + SQS_W'(sq_ff[k]);
               end
               learn_count_ff <= learn_count_ff + LEARN_COUNT_BITS'(1);
               state_ff       <= S_IDLE;
            end

            S_FIN_MEAN_DIV: begin
               if (step_cnt_ff != '0) begin
                  div_num_ff  <= div_quo;
                  div_rem_ff  <= div_rem_sub[DDW-1:0];
                  step_cnt_ff <= step_cnt_ff - STEP_W'(1);
               end else begin
                  mean_ff[midx_ff] <= div_quo[METRIC_W-1:0];
                  if (learn_count_ff > LEARN_COUNT_BITS'(1)) begin
                     div_num_ff  <= DVW'(sqs_ff[midx_ff]);
                     div_rem_ff  <= '0;
                     step_cnt_ff <= STEP_W'(DVW - 1);
                     state_ff    <= S_FIN_EX2_DIV;
                  end else begin
                     // Fewer than two samples: no spread.
                     std_ff[midx_ff] <= '0;
                     if (midx_ff == METRIC_LAST) begin
                        baseline_ready_ff <= 1'b1;
                        state_ff          <= S_IDLE;
                     end else begin
                        midx_ff     <= midx_ff + 2'd1;
                        div_num_ff  <= DVW'(sum_ff[midx_ff + 2'd1]);
                        div_rem_ff  <= '0;
                        step_cnt_ff <= STEP_W'(DVW - 1);
                     end
                  end
               end
            end

            S_FIN_EX2_DIV: begin
               div_num_ff  <= div_quo;
               div_rem_ff  <= div_rem_sub[DDW-1:0];
               step_cnt_ff <= step_cnt_ff - STEP_W'(1);
               if (step_cnt_ff == '0) begin
                  ex2_ff   <= div_quo[2*METRIC_W-1:0];
                  state_ff <= S_FIN_MSQ;
               end
            end

            S_FIN_MSQ: begin
               msq_ff   <= mean_ff[midx_ff] * mean_ff[midx_ff];
               state_ff <= S_FIN_VAR;
            end

            S_FIN_VAR: begin
               // Negative variance from rounding clamps to zero.
               sq_val_ff   <= (ex2_ff > msq_ff) ? (ex2_ff - msq_ff) : '0;
               sq_rem_ff   <= '0;
               sq_root_ff  <= '0;
               step_cnt_ff <= STEP_W'(SQ_STEPS - 1);
               state_ff    <= S_FIN_SQRT;
            end

            S_FIN_SQRT: begin
               if (step_cnt_ff != '0) begin
                  sq_val_ff   <= {sq_val_ff[29:0], 2'b00};
                  sq_rem_ff   <= sq_rem_sub[17:0];
                  sq_root_ff  <= sq_root_nx;
                  step_cnt_ff <= step_cnt_ff - STEP_W'(1);
               end else begin
                  std_ff[midx_ff] <= sq_root_nx;
                  if (midx_ff == METRIC_LAST) begin
                     baseline_ready_ff <= 1'b1;
                     state_ff          <= S_IDLE;
                  end else begin
                     midx_ff     <= midx_ff + 2'd1;
                     div_num_ff  <= DVW'(sum_ff[midx_ff + 2'd1]);
                     div_rem_ff  <= '0;
                     step_cnt_ff <= STEP_W'(DVW - 1);
                     state_ff    <= S_FIN_MEAN_DIV;
                  end
               end
            end

            S_DET_LOAD: begin
               if (std_ff[midx_ff] == '0) begin
                  z_ff[midx_ff] <= '0;
                  if (midx_ff == METRIC_LAST) begin
                     state_ff <= S_DET_FLAGS;
                  end else begin
                     midx_ff <= midx_ff + 2'd1;
                  end
               end else begin
                  div_num_ff  <= DVW'({dev_mag, 8'h00});
                  div_den_ff  <= DDW'(std_ff[midx_ff]);
                  div_rem_ff  <= '0;
                  zneg_ff     <= dev[METRIC_W];
                  step_cnt_ff <= STEP_W'(DVW - 1);
                  state_ff    <= S_DET_DIV;
               end
            end

            S_DET_DIV: begin
               div_num_ff  <= div_quo;
               div_rem_ff  <= div_rem_sub[DDW-1:0];
               step_cnt_ff <= step_cnt_ff - STEP_W'(1);
               if (step_cnt_ff == '0) begin
                  // Truncate toward zero, then saturate to Q8.8.
                  if (!zneg_ff) begin
                     z_ff[midx_ff] <= (div_quo > DVW'(32767)) ? 16'sh7FFF : div_quo[15:0];
                  end else begin
                     z_ff[midx_ff] <= (div_quo > DVW'(32768)) ? 16'sh8000
                                                             : (16'd0 - div_quo[15:0]);
                  end
                  if (midx_ff == METRIC_LAST) begin
                     state_ff <= S_DET_FLAGS;
                  end else begin
                     midx_ff  <= midx_ff + 2'd1;
                     state_ff <= S_DET_LOAD;
                  end
               end
            end

            S_DET_FLAGS: begin
               flags_ff       <= {1'b0, burst, spike};
               run_ff         <= run_nx;
               res_count_ff   <= run_nx;
               ring_pos_ff    <= pos_next;
               osc_addr_ff    <= pos_sel;
               osc_left_ff    <= cap;
               osc_pend_ff    <= 1'b0;
               osc_first_ff   <= 1'b1;
               osc_dir_ff     <= DIR_NONE;
               osc_changes_ff <= '0;
               state_ff       <= S_OSC;
            end

            S_OSC: begin
               // Issue one read a cycle, newest entry first.
               if (osc_left_ff != '0) begin
                  osc_addr_ff <= (osc_addr_ff == '0) ? AW'(cap - CW'(1))
                                                     : (osc_addr_ff - AW'(1));
                  osc_left_ff <= osc_left_ff - CW'(1);
               end
               osc_pend_ff <= (osc_left_ff != '0);
               // Count sign changes of successive differences.
               if (osc_pend_ff) begin
                  osc_prev_ff  <= osc_entry;
                  osc_first_ff <= 1'b0;
                  if (!osc_first_ff && osc_dir != DIR_NONE) begin
                     if (osc_dir_ff != DIR_NONE && osc_dir != osc_dir_ff) begin
                        osc_changes_ff <= osc_changes_ff + CW'(1);
                     end
                     osc_dir_ff <= osc_dir;
                  end
               end
               if (osc_done) begin
                  flags_ff[4] <= osc_flag;
                  if (score_den == '0) begin
                     score_ff <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     div_num_ff  <= DVW'({maxz, 16'h0000});
                     div_den_ff  <= DDW'(score_den);
                     div_rem_ff  <= '0;
                     step_cnt_ff <= STEP_W'(DVW - 1);
                     state_ff    <= S_SCORE_DIV;
                  end
               end
            end

            S_SCORE_DIV: begin
               div_num_ff  <= div_quo;
               div_rem_ff  <= div_rem_sub[DDW-1:0];
               step_cnt_ff <= step_cnt_ff - STEP_W'(1);
               if (step_cnt_ff == '0) begin
                  score_ff <= (div_quo > DVW'(65535)) ? 16'hFFFF : div_quo[15:0];
                  state_ff <= S_OUT;
               end
            end

            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  for (int k = 0; k < 3; k++) rsp_z_ff[k] <= z_ff[k];
                  rsp_flags_ff <= flags_ff;
                  rsp_count_ff <= res_count_ff;
                  rsp_score_ff <= score_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_wa] <= x_ff[0];
      ring_rd_ff <= ring_mem[osc_addr_ff];
   end

   // Valid bits: entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff    <= '0;
         ring_rd_vld_ff <= 1'b0;
      end else begin
         if (ring_we) ring_vld_ff[ring_wa] <= 1'b1;
         ring_rd_vld_ff <= ring_vld_ff[osc_addr_ff];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.z_cache        = rsp_z_ff[0];
   assign rsp_chan.z_branch       = rsp_z_ff[1];
   assign rsp_chan.z_ipc          = rsp_z_ff[2];
   assign rsp_chan.flags          = rsp_flags_ff;
   assign rsp_chan.anomaly_streak = rsp_count_ff;
   assign rsp_chan.score          = rsp_score_ff;

`ifndef NO_ASSERTIONS
   // A burst is only reported together with a nonzero run.
   a_burst_has_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff[3]) |-> (rsp_count_ff != '0))
      else $error("burst flagged with an empty run");

   // A new response appears only from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output state");

   // The ring position stays inside the memory.
   a_ring_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(ring_pos_ff) < 32'(HISTORY_DEPTH))
      else $error("ring position out of range");

   // The walk never issues more reads than the window holds.
   a_osc_left_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OSC) |-> (osc_left_ff <= cap))
      else $error("oscillation walk overran the window");
`endif

endmodule : telemetry_zscore_anomaly_detector
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the telemetry z-score anomaly detector: drives learn,
// finalize and detect requests with random idling and compares each response
// with an internal prediction. Depends on tzad_pkg and tzad_channels_if.sv.

// Holds the predicted state of the detector and the queue of expected responses.
class zscore_scoreboard;
   typedef struct packed {
      logic signed [15:0] z_cache;
      logic signed [15:0] z_branch;
      logic signed [15:0] z_ipc;
      logic [4:0]         flags;
      logic [15:0]        anomaly_streak;
      logic [15:0]        score;
   } verdict_type;

   logic [63:0] sum_acc [3];
   logic [63:0] sq_acc [3];
   logic [63:0] learned_total;
   logic [31:0] mean_val [3];
   logic [31:0] std_val [3];
   bit          baseline_ok;
   logic [15:0] cache_ring [64];
   int unsigned ring_pos;
   int unsigned anomaly_run;
   int unsigned z_limit;
   int unsigned window_len;
   verdict_type pending_verdicts [$];
   int          mismatch_count;

   function new();
      sum_acc = '{default: 0};
      sq_acc = '{default: 0};
      mean_val = '{default: 0};
      std_val = '{default: 0};
      cache_ring = '{default: 0};
      learned_total = 0;
      baseline_ok = 0;
      ring_pos = 0;
      anomaly_run = 0;
      z_limit = 768;
      window_len = 8;
      mismatch_count = 0;
   endfunction

   function void write_reg(logic idx, int unsigned value);
      if (idx == tzad_pkg::CSR_Z_LIMIT) z_limit = value & 16'hFFFF;
      else window_len = value & 7'h7F;
   endfunction

   // Integer square root by the usual bit-pair method.
   function logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function int z_of(logic [15:0] x, logic [31:0] m, logic [31:0] sd);
      longint num, q;
      if (sd == 0) return 0;
      num = (longint'(x) - longint'(m)) * 256;
      q = num / longint'(sd);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   // Notes one accepted request and queues the response it should cause.
   function void note_request(logic [1:0] op, logic [15:0] cr, logic [15:0] br,
                              logic [15:0] ipc);
      logic [15:0] x [3];
      int          z [3];
      verdict_type v;
      int unsigned cap, pos, idx, maxz, den, changes, a, b, i;
      int          dir, prev;
      longint unsigned sc, m, ex2, var_v;
      x[0] = cr; x[1] = br; x[2] = ipc;
      if (op == tzad_pkg::OP_LEARN) begin
         if (learned_total >= (64'd1 << 20) - 1) return;
         for (int k = 0; k < 3; k++) begin
            sum_acc[k] += 64'(x[k]);
            sq_acc[k] += 64'(x[k]) * 64'(x[k]);
         end
         learned_total++;
         return;
      end
      if (op == tzad_pkg::OP_FINALIZE) begin
         if (learned_total == 0) return;
         for (int k = 0; k < 3; k++) begin
            m = sum_acc[k] / learned_total;
            var_v = 0;
            if (learned_total >= 2) begin
               ex2 = sq_acc[k] / learned_total;
               var_v = (ex2 > m * m) ? ex2 - m * m : 0;
            end
            mean_val[k] = 32'(m);
            std_val[k] = int_sqrt(var_v);
         end
         baseline_ok = 1;
         return;
      end
      if (op != tzad_pkg::OP_DETECT) return;
      v = '0;
      if (!baseline_ok) begin
         pending_verdicts.push_back(v);
         return;
      end
      for (int k = 0; k < 3; k++) z[k] = z_of(x[k], mean_val[k], std_val[k]);
      if (z[0] > int'(z_limit)) v.flags[0] = 1;
      if (z[1] > int'(z_limit)) v.flags[1] = 1;
      if (z[2] < -int'(z_limit)) v.flags[2] = 1;
      cap = (window_len == 0) ? 1 : (window_len > 64 ? 64 : window_len);
      pos = (ring_pos < cap) ? ring_pos : 0;
      cache_ring[pos] = cr;
      ring_pos = (pos + 1) % cap;
      if (v.flags[2:0] != 0) begin
         if (anomaly_run < 65535) anomaly_run++;
         if (anomaly_run >= cap) v.flags[3] = 1;
      end else begin
         anomaly_run = 0;
      end
      // Count direction changes over the ring, newest to oldest.
      if (cap >= 4) begin
         changes = 0;
         prev = 0;
         idx = ring_pos;
         for (i = 1; i < cap; i++) begin
            a = (idx + cap - i) % cap;
            b = (idx + 2 * cap - i - 1) % cap;
            dir = 0;
            if (cache_ring[a] > cache_ring[b]) dir = 1;
            else if (cache_ring[a] < cache_ring[b]) dir = -1;
            if (dir != 0 && prev != 0 && dir != prev) changes++;
            if (dir != 0) prev = dir;
         end
         if (changes >= cap / 2) v.flags[4] = 1;
      end
      maxz = 0;
      for (int k = 0; k < 3; k++)
         if ((z[k] < 0 ? -z[k] : z[k]) > maxz) maxz = (z[k] < 0 ? -z[k] : z[k]);
      den = z_limit + maxz;
      sc = (den == 0) ? 0 : (longint'(maxz) << 16) / den;
      if (sc > 65535) sc = 65535;
      v.z_cache = 16'(z[0]);
      v.z_branch = 16'(z[1]);
      v.z_ipc = 16'(z[2]);
      v.anomaly_streak = 16'(anomaly_run);
      v.score = 16'(sc);
      pending_verdicts.push_back(v);
   endfunction

   // Compares one response with the oldest expectation.
   function void check_response(verdict_type got);
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Unexpected response %h", got);
         return;
      end
      want = pending_verdicts.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Mismatch: expected z %0d %0d %0d fl %b run %0d sc %0d",
                     want.z_cache, want.z_branch, want.z_ipc, want.flags,
                     want.anomaly_streak, want.score);
            $display("          got z %0d %0d %0d fl %b run %0d sc %0d",
                     got.z_cache, got.z_branch, got.z_ipc, got.flags,
                     got.anomaly_streak, got.score);
         end
      end
   endfunction
endclass

module tb_top;
   import tzad_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit   idle_enabled;
   int   hold_cycles;

   tzad_req_if req_chan ();
   tzad_rsp_if rsp_chan ();
   zscore_scoreboard board;

   telemetry_zscore_anomaly_detector DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run limit, well above the slowest correct run.
   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off when requested.
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 0;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 3) - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response({rsp_chan.z_cache, rsp_chan.z_branch, rsp_chan.z_ipc,
                               rsp_chan.flags, rsp_chan.anomaly_streak, rsp_chan.score});

   // Sends one request and waits until it is accepted; valid stays up for the next.
   task automatic send_request(logic [1:0] op, logic [15:0] cr, logic [15:0] br,
                               logic [15:0] ipc);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.op <= op;
      req_chan.cache_rate <= cr;
      req_chan.branch_rate <= br;
      req_chan.ipc_value <= ipc;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(op, cr, br, ipc);
   endtask

   // Waits until every response has come, then lets a finalize settle.
   task automatic drain_responses();
      req_chan.valid <= 0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      drain_responses();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, value);
   endtask

   // A baseline built from samples around a random center, then a finalize.
   task automatic learn_baseline(int n);
      logic [15:0] c0, c1, c2;
      c0 = 16'($urandom); c1 = 16'($urandom); c2 = 16'($urandom);
      repeat (n)
         send_request(OP_LEARN, c0 + 16'($urandom_range(0, 2000)),
                      c1 + 16'($urandom_range(0, 2000)),
                      c2 + 16'($urandom_range(0, 2000)));
      send_request(OP_FINALIZE, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic [15:0] rand_metric();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      board = new();
      reset = 1;
      csr_we = 0;
      csr_index = CSR_Z_LIMIT;
      csr_wdata = 0;
      idle_enabled = 1;
      hold_cycles = 0;
      req_chan.valid = 0;
      req_chan.op = OP_LEARN;
      req_chan.cache_rate = 0;
      req_chan.branch_rate = 0;
      req_chan.ipc_value = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: detect and finalize before any learning, unknown op.
      send_request(OP_DETECT, 16'hFFFF, 0, 16'hFFFF);
      send_request(OP_FINALIZE, 1, 2, 3);
      send_request(OP_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_DETECT, 5, 5, 5);
      // One sample gives zero spread, so every z-score is zero.
      send_request(OP_LEARN, 16'hFFFF, 0, 16'h8000);
      send_request(OP_FINALIZE, 0, 0, 0);
      send_request(OP_DETECT, 0, 16'hFFFF, 0);
      // Extremes of the fields give wide spread.
      send_request(OP_LEARN, 0, 16'hFFFF, 0);
      send_request(OP_LEARN, 16'h0100, 16'h0100, 16'h0100);
      send_request(OP_FINALIZE, 0, 0, 0);
      send_request(OP_DETECT, 16'hFFFF, 16'hFFFF, 0);
      send_request(OP_DETECT, 0, 0, 16'hFFFF);
      send_request(OP_DETECT, 16'hFFFF, 0, 16'hFFFF);
      send_request(OP_DETECT, 0, 16'hFFFF, 0);

      // Configuration phases, extremes included; the last ones are random.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_reg(CSR_Z_LIMIT, 1); write_reg(CSR_WINDOW_LEN, 4); end
            1: begin write_reg(CSR_Z_LIMIT, 65535); write_reg(CSR_WINDOW_LEN, 64); end
            2: begin write_reg(CSR_Z_LIMIT, 0); write_reg(CSR_WINDOW_LEN, 1); end
            3: begin write_reg(CSR_Z_LIMIT, 256); write_reg(CSR_WINDOW_LEN, 127); end
            4: begin write_reg(CSR_Z_LIMIT, 512); write_reg(CSR_WINDOW_LEN, 0); end
            default: begin
               write_reg(CSR_Z_LIMIT, $urandom_range(1, 1024));
               write_reg(CSR_WINDOW_LEN, $urandom_range(2, 12));
            end
         endcase
         if (phase == 7) idle_enabled = 0;
         if ($urandom_range(0, 1)) learn_baseline($urandom_range(3, 12));
         // The receiver holds off while requests keep coming.
         if (phase == 1) hold_cycles = 2000;
         for (int i = 0; i < 70; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(2'($urandom_range(0, 3)), rand_metric(), rand_metric(),
                            rand_metric());
            else if ($urandom_range(0, 3) == 0)
               // Alternating cache rates to provoke oscillation.
               send_request(OP_DETECT, (i % 2) ? 16'hF000 : 16'h0100, rand_metric(),
                            rand_metric());
            else
               send_request(OP_DETECT, rand_metric(), rand_metric(), rand_metric());
            if (i == 35) drain_responses();
         end
      end

      drain_responses();
      if (board.mismatch_count == 0 && board.pending_verdicts.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
